### rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// rbst_pkg: shared types, constants and single-precision helpers for the slab test
package rbst_pkg;

    // pipeline shape
    localparam int SIG_W         = 27;
    localparam int DIV_STEPS     = 28;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
    localparam int RECIP_LAT     = DIV_STAGES + 2;
    localparam int SUB_LAT       = 4;
    localparam int MUL_LAT       = 3;
    localparam int NARROW_LAT    = 4;
    localparam int NSTAGE        = RECIP_LAT + MUL_LAT + NARROW_LAT;
    localparam int NAX           = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    typedef logic [31:0]        fp_t;
    typedef logic [SIG_W-1:0]   sig_t;
    typedef logic signed [11:0] exp_t;

    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
        logic sign;
    } spec_t;

    typedef struct packed {
        logic [24:0] rem;
        logic [27:0] quo;
    } div_t;

    localparam fp_t FP_QNAN = 32'h7fc0_0000;

    function automatic logic f_is_nan(fp_t a);
        return (&a[30:23]) & (|a[22:0]);
    endfunction

    function automatic logic f_is_inf(fp_t a);
        return (&a[30:23]) & ~(|a[22:0]);
    endfunction

    function automatic logic f_is_zero(fp_t a);
        return ~(|a[30:0]);
    endfunction

    // IEEE a < b: false on NaN, signed zeros equal
    function automatic logic f_lt(fp_t a, fp_t b);
        logic r;
        if (f_is_nan(a) || f_is_nan(b))
            r = 1'b0;
        else if (f_is_zero(a) && f_is_zero(b))
            r = 1'b0;
        else if (a[31] != b[31])
            r = a[31];
        else if (!a[31])
            r = (a[30:0] < b[30:0]);
        else
            r = (a[30:0] > b[30:0]);
        return r;
    endfunction

    function automatic logic [5:0] lzc48(logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i])
            begin
                n     = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // sig has its leading one at bit 26 (normal), bits 1:0 act as sticky.
    // e is the biased exponent; results below 1 are denormalised here.
    function automatic fp_t round_pack(logic sign, exp_t e, sig_t sig);
        sig_t        s;
        sig_t        mask;
        exp_t        amt;
        logic [7:0]  ef;
        logic        inc;
        logic [30:0] mag;
        fp_t         res;
        s    = sig;
        mask = '0;
        amt  = '0;
        ef   = '0;
        if (e >= exp_t'(255))
            res = {sign, 8'hff, 23'd0};
        else
        begin
            if (e >= exp_t'(1))
                ef = e[7:0];
            else
            begin
                amt = exp_t'(1) - e;
                if (amt >= exp_t'(SIG_W))
                    s = {{(SIG_W-1){1'b0}}, |sig};
                else
                begin
                    mask = ~({SIG_W{1'b1}} << amt[4:0]);
                    s    = sig >> amt[4:0];
                    s[0] = s[0] | (|(sig & mask));
                end
            end
            inc = s[2] & ((|s[1:0]) | s[3]);
            mag = {ef, s[25:3]} + 31'(inc);
            res = {sign, mag};
        end
        return res;
    endfunction

    function automatic fp_t apply_spec(spec_t sp, fp_t v);
        fp_t r;
        if (sp.nan)
            r = FP_QNAN;
        else if (sp.inf)
            r = {sp.sign, 8'hff, 23'd0};
        else if (sp.zero)
            r = {sp.sign, 31'd0};
        else
            r = v;
        return r;
    endfunction

    // a few restoring steps of 2^50 / m
    function automatic div_t div_chunk(div_t d, logic [23:0] m);
        div_t x;
        logic qb;
        x = d;
        for (int i = 0; i < DIV_PER_STAGE; i++) begin
            qb = (x.rem >= {1'b0, m});
            if (qb)
                x.rem = x.rem - {1'b0, m};
            x.quo = {x.quo[26:0], qb};
            x.rem = {x.rem[23:0], 1'b0};
        end
        return x;
    endfunction

endpackage

### rtl/rbst_fsub.sv
`timescale 1ns / 1ps
// rbst_fsub: four-stage single-precision subtractor y = a - b
module rbst_fsub (
    input  logic                         clk,
    input  logic [rbst_pkg::SUB_LAT-1:0] en,
    input  rbst_pkg::fp_t                a,
    input  rbst_pkg::fp_t                b,
    output rbst_pkg::fp_t                y
);
    import rbst_pkg::*;

    // stage 1: swap and align
    fp_t         bn, big, sml;
    logic        swap;
    logic [7:0]  eb, es, d;
    logic [23:0] mb, ms;
    sig_t        ms_ext, al;
    spec_t       sp1;

    logic        s1_sb_reg, s1_ss_reg;
    logic [7:0]  s1_e_reg;
    sig_t        s1_mb_reg, s1_ms_reg;
    spec_t       s1_spec_reg;

    always_comb
    begin
        bn     = {~b[31], b[30:0]};
        swap   = (a[30:0] < bn[30:0]);
        big    = swap ? bn : a;
        sml    = swap ? a : bn;
        eb     = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es     = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb     = {|big[30:23], big[22:0]};
        ms     = {|sml[30:23], sml[22:0]};
        d      = eb - es;
        ms_ext = {ms, 3'b000};
        if (d >= 8'(SIG_W))
            al = {{(SIG_W-1){1'b0}}, |ms};
        else
        begin
            al    = ms_ext >> d[4:0];
            al[0] = al[0] | (|(ms_ext & ~({SIG_W{1'b1}} << d[4:0])));
        end
        sp1.nan  = f_is_nan(a) | f_is_nan(b) |
                   (f_is_inf(a) & f_is_inf(b) & (a[31] != bn[31]));
        sp1.inf  = f_is_inf(a) | f_is_inf(b);
        sp1.zero = 1'b0;
        sp1.sign = f_is_inf(a) ? a[31] : bn[31];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_sb_reg   <= big[31];
            s1_ss_reg   <= sml[31];
            s1_e_reg    <= eb;
            s1_mb_reg   <= {mb, 3'b000};
            s1_ms_reg   <= al;
            s1_spec_reg <= sp1;
        end
    end

    // stage 2: add or subtract magnitudes
    logic [27:0] sum;
    logic [27:0] s2_sum_reg;
    logic [7:0]  s2_e_reg;
    logic        s2_sign_reg, s2_zsign_reg;
    spec_t       s2_spec_reg;

    always_comb
    begin
        if (s1_sb_reg == s1_ss_reg)
            sum = {1'b0, s1_mb_reg} + {1'b0, s1_ms_reg};
        else
            sum = {1'b0, s1_mb_reg} - {1'b0, s1_ms_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_sum_reg   <= sum;
            s2_e_reg     <= s1_e_reg;
            s2_sign_reg  <= s1_sb_reg;
            s2_zsign_reg <= s1_sb_reg & s1_ss_reg;
            s2_spec_reg  <= s1_spec_reg;
        end
    end

    // stage 3: normalise
    logic [5:0]  lz;
    logic [27:0] shv;
    spec_t       sp3;
    logic        s3_sign_reg;
    exp_t        s3_e_reg;
    sig_t        s3_sig_reg;
    spec_t       s3_spec_reg;

    always_comb
    begin
        lz  = lzc48({s2_sum_reg, 20'd0});
        shv = s2_sum_reg << lz;
        sp3 = s2_spec_reg;
        if (!sp3.nan && !sp3.inf && (s2_sum_reg == 28'd0))
        begin
            sp3.zero = 1'b1;
            sp3.sign = s2_zsign_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_sign_reg <= s2_sign_reg;
            s3_e_reg    <= exp_t'(s2_e_reg) + exp_t'(1) - exp_t'(lz);
            s3_sig_reg  <= {shv[27:2], shv[1] | shv[0]};
            s3_spec_reg <= sp3;
        end
    end

    // stage 4: round
    fp_t y_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
            y_reg <= apply_spec(s3_spec_reg, round_pack(s3_sign_reg, s3_e_reg, s3_sig_reg));
    end

    assign y = y_reg;

endmodule

### rtl/rbst_fmul.sv
`timescale 1ns / 1ps
// rbst_fmul: three-stage single-precision multiplier
module rbst_fmul (
    input  logic                         clk,
    input  logic [rbst_pkg::MUL_LAT-1:0] en,
    input  rbst_pkg::fp_t                a,
    input  rbst_pkg::fp_t                b,
    output rbst_pkg::fp_t                y
);
    import rbst_pkg::*;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    spec_t       sp1;

    logic [47:0] m1_prod_reg;
    logic [8:0]  m1_esum_reg;
    spec_t       m1_spec_reg;

    always_comb
    begin
        ea       = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb       = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma       = {|a[30:23], a[22:0]};
        mb       = {|b[30:23], b[22:0]};
        sp1.nan  = f_is_nan(a) | f_is_nan(b) |
                   (f_is_inf(a) & f_is_zero(b)) | (f_is_zero(a) & f_is_inf(b));
        sp1.inf  = f_is_inf(a) | f_is_inf(b);
        sp1.zero = f_is_zero(a) | f_is_zero(b);
        sp1.sign = a[31] ^ b[31];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m1_prod_reg <= ma * mb;
            m1_esum_reg <= 9'(ea) + 9'(eb);
            m1_spec_reg <= sp1;
        end
    end

    // normalise the product
    logic [5:0]  lz;
    logic [47:0] shv;
    exp_t        m2_e_reg;
    sig_t        m2_sig_reg;
    spec_t       m2_spec_reg;

    always_comb
    begin
        lz  = lzc48(m1_prod_reg);
        shv = m1_prod_reg << lz;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m2_e_reg    <= exp_t'(m1_esum_reg) - exp_t'(126) - exp_t'(lz);
            m2_sig_reg  <= {shv[47:22], shv[21] | (|shv[20:0])};
            m2_spec_reg <= m1_spec_reg;
        end
    end

    fp_t y_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
            y_reg <= apply_spec(m2_spec_reg,
                                round_pack(m2_spec_reg.sign, m2_e_reg, m2_sig_reg));
    end

    assign y = y_reg;

endmodule

### rtl/rbst_recip.sv
`timescale 1ns / 1ps
// rbst_recip: pipelined single-precision reciprocal 1.0 / d
module rbst_recip (
    input  logic                           clk,
    input  logic [rbst_pkg::RECIP_LAT-1:0] en,
    input  rbst_pkg::fp_t                  d,
    output rbst_pkg::fp_t                  y
);
    import rbst_pkg::*;

    // unpack, normalise denormal divisors
    logic [7:0]  ed;
    logic [23:0] md, mn;
    logic [5:0]  lz;
    spec_t       sp0;

    logic [23:0] m_reg    [0:DIV_STAGES-1];
    exp_t        e_reg    [0:DIV_STAGES];
    spec_t       spec_reg [0:DIV_STAGES];
    div_t        div_reg  [0:DIV_STAGES];

    always_comb
    begin
        ed       = (d[30:23] == 8'd0) ? 8'd1 : d[30:23];
        md       = {|d[30:23], d[22:0]};
        lz       = lzc48({md, 24'd0});
        mn       = md << lz;
        sp0.nan  = f_is_nan(d);
        sp0.inf  = f_is_zero(d);
        sp0.zero = f_is_inf(d);
        sp0.sign = d[31];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m_reg[0]    <= mn;
            e_reg[0]    <= exp_t'(253) - exp_t'(ed) + exp_t'(lz);
            spec_reg[0] <= sp0;
            div_reg[0]  <= '{rem: 25'(1 << 23), quo: '0};
        end
    end

    // quotient bits, a few per stage
    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                div_reg[j]  <= div_chunk(div_reg[j-1], m_reg[j-1]);
                e_reg[j]    <= e_reg[j-1];
                spec_reg[j] <= spec_reg[j-1];
            end
        end
        if (j < DIV_STAGES) begin : g_m
            always_ff @(posedge clk)
            begin
                if (en[j])
                    m_reg[j] <= m_reg[j-1];
            end
        end
    end

    // round; a power-of-two divisor gives an exact quotient of 2^27
    div_t dq;
    sig_t sig;
    exp_t ef;
    fp_t  y_reg;

    always_comb
    begin
        dq = div_reg[DIV_STAGES];
        if (dq.quo[27])
        begin
            sig = dq.quo[27:1];
            ef  = e_reg[DIV_STAGES] + exp_t'(1);
        end
        else
        begin
            sig = {dq.quo[26:1], dq.quo[0] | (|dq.rem)};
            ef  = e_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_STAGES+1])
            y_reg <= apply_spec(spec_reg[DIV_STAGES],
                                round_pack(spec_reg[DIV_STAGES].sign, ef, sig));
    end

    assign y = y_reg;

endmodule

### rtl/rbst_narrow.sv
`timescale 1ns / 1ps
// rbst_narrow: slab ordering and interval narrowing, one axis per stage
module rbst_narrow (
    input  logic                            clk,
    input  logic [rbst_pkg::NARROW_LAT-1:0] en,
    input  rbst_pkg::fp_t [2:0]             tn,
    input  rbst_pkg::fp_t [2:0]             tf,
    input  rbst_pkg::fp_t                   t_lo,
    input  rbst_pkg::fp_t                   t_hi,
    output logic                            hit,
    output rbst_pkg::fp_t                   t_entry
);
    import rbst_pkg::*;

    fp_t  near_reg [0:NAX-1][0:NAX-1];
    fp_t  far_reg  [0:NAX-1][0:NAX-1];
    fp_t  lo_reg   [0:NAX];
    fp_t  hi_reg   [0:NAX-1];
    logic miss_reg [0:NAX];

    // order near/far per axis
    for (genvar i = 0; i < NAX; i++) begin : g_swap
        logic sw;
        assign sw = f_lt(tf[i], tn[i]);
        always_ff @(posedge clk)
        begin
            if (en[0])
            begin
                near_reg[0][i] <= sw ? tf[i] : tn[i];
                far_reg[0][i]  <= sw ? tn[i] : tf[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_reg[0]   <= t_lo;
            hi_reg[0]   <= t_hi;
            miss_reg[0] <= 1'b0;
        end
    end

    // axis k-1 narrows the interval in stage k
    for (genvar k = 1; k <= NAX; k++) begin : g_axis
        fp_t lo_next, hi_next;
        assign lo_next = f_lt(lo_reg[k-1], near_reg[k-1][k-1]) ?
                         near_reg[k-1][k-1] : lo_reg[k-1];
        assign hi_next = f_lt(far_reg[k-1][k-1], hi_reg[k-1]) ?
                         far_reg[k-1][k-1] : hi_reg[k-1];
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                lo_reg[k]   <= lo_next;
                miss_reg[k] <= miss_reg[k-1] | f_lt(hi_next, lo_next);
            end
        end
        if (k < NAX) begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    hi_reg[k] <= hi_next;
                    for (int i = 0; i < NAX; i++) begin
                        near_reg[k][i] <= near_reg[k-1][i];
                        far_reg[k][i]  <= far_reg[k-1][i];
                    end
                end
            end
        end
    end

    assign hit     = ~miss_reg[NAX];
    assign t_entry = miss_reg[NAX] ? '0 : lo_reg[NAX];

endmodule

### rtl/ray_box_slab_test.sv
`timescale 1ns / 1ps
// ray_box_slab_test: ray against axis-aligned box, slab method, single precision
//
// Input channel (in_valid / in_stall): one ray per transaction, origin,
// direction and the [t_start, t_limit] parameter interval as IEEE singles.
// Output channel (out_valid / out_stall): one result per ray, hit and the
// entry distance (zero on a miss), in the order the rays arrived.
// Config channel (cfg_valid / cfg_ready): writes the six box corner
// registers by index 0..5; other indexes are dropped. cfg_ready is always
// high. Write only while no ray is in flight.
// The pipeline runs the reciprocal (a 4-bit-per-stage restoring divider
// plus unpack and round stages), the multiply, then slab ordering and
// one narrowing stage per axis. The box subtraction runs alongside the
// reciprocal.
// Throughput is one ray per cycle while in_stall is low. When the receiver
// stalls, the pipeline keeps filling its empty stages and stalls the
// sender only once every stage holds a transaction.
// Reset clears the valid bits and the box registers (all corners +0).
module ray_box_slab_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rbst_pkg::fp_t                       origin_x,
    input  rbst_pkg::fp_t                       origin_y,
    input  rbst_pkg::fp_t                       origin_z,
    input  rbst_pkg::fp_t                       dir_x,
    input  rbst_pkg::fp_t                       dir_y,
    input  rbst_pkg::fp_t                       dir_z,
    input  rbst_pkg::fp_t                       t_start,
    input  rbst_pkg::fp_t                       t_limit,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output rbst_pkg::fp_t                       t_entry,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  rbst_pkg::fp_t                       cfg_data
);
    import rbst_pkg::*;

    localparam int SUB_DLY = RECIP_LAT - SUB_LAT;
    localparam int T_DLY   = RECIP_LAT + MUL_LAT;

    // ---------------------------------------------------------------
    // Stage control: a stage may load when it or any later stage is
    // empty, or the output is being taken.
    // ---------------------------------------------------------------
    logic [NSTAGE-1:0] v_reg, v_next, en;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_en
        assign en[k] = ~out_stall | ~(&v_reg[NSTAGE-1:k]);
    end

    assign v_next = {v_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= (v_next & en) | (v_reg & ~en);
    end

    assign in_stall  = ~en[0];
    assign out_valid = v_reg[NSTAGE-1];

    // ---------------------------------------------------------------
    // Box corner registers
    // ---------------------------------------------------------------
    fp_t box_min_reg [0:NAX-1];
    fp_t box_max_reg [0:NAX-1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NAX; i++) begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Per-axis datapath: reciprocal, corner - origin, slab distances
    // ---------------------------------------------------------------
    fp_t        org  [0:NAX-1];
    fp_t        dirv [0:NAX-1];
    fp_t [2:0]  tn, tf;

    assign org[0]  = origin_x;
    assign org[1]  = origin_y;
    assign org[2]  = origin_z;
    assign dirv[0] = dir_x;
    assign dirv[1] = dir_y;
    assign dirv[2] = dir_z;

    for (genvar i = 0; i < NAX; i++) begin : g_axis
        fp_t recip, dn, df;
        fp_t dn_dly_reg [0:SUB_DLY-1];
        fp_t df_dly_reg [0:SUB_DLY-1];

        rbst_recip u_recip (
            .clk (clk),
            .en  (en[RECIP_LAT-1:0]),
            .d   (dirv[i]),
            .y   (recip)
        );

        rbst_fsub u_sub_near (
            .clk (clk),
            .en  (en[SUB_LAT-1:0]),
            .a   (box_min_reg[i]),
            .b   (org[i]),
            .y   (dn)
        );

        rbst_fsub u_sub_far (
            .clk (clk),
            .en  (en[SUB_LAT-1:0]),
            .a   (box_max_reg[i]),
            .b   (org[i]),
            .y   (df)
        );

        // hold the differences until the reciprocal is ready
        always_ff @(posedge clk)
        begin
            if (en[SUB_LAT])
            begin
                dn_dly_reg[0] <= dn;
                df_dly_reg[0] <= df;
            end
            for (int j = 1; j < SUB_DLY; j++) begin
                if (en[SUB_LAT+j])
                begin
                    dn_dly_reg[j] <= dn_dly_reg[j-1];
                    df_dly_reg[j] <= df_dly_reg[j-1];
                end
            end
        end

        rbst_fmul u_mul_near (
            .clk (clk),
            .en  (en[RECIP_LAT +: MUL_LAT]),
            .a   (dn_dly_reg[SUB_DLY-1]),
            .b   (recip),
            .y   (tn[i])
        );

        rbst_fmul u_mul_far (
            .clk (clk),
            .en  (en[RECIP_LAT +: MUL_LAT]),
            .a   (df_dly_reg[SUB_DLY-1]),
            .b   (recip),
            .y   (tf[i])
        );
    end

    // ---------------------------------------------------------------
    // Interval bounds travel alongside the slab arithmetic
    // ---------------------------------------------------------------
    fp_t t_lo_dly_reg [0:T_DLY-1];
    fp_t t_hi_dly_reg [0:T_DLY-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t_lo_dly_reg[0] <= t_start;
            t_hi_dly_reg[0] <= t_limit;
        end
        for (int j = 1; j < T_DLY; j++) begin
            if (en[j])
            begin
                t_lo_dly_reg[j] <= t_lo_dly_reg[j-1];
                t_hi_dly_reg[j] <= t_hi_dly_reg[j-1];
            end
        end
    end

    rbst_narrow u_narrow (
        .clk     (clk),
        .en      (en[T_DLY +: NARROW_LAT]),
        .tn      (tn),
        .tf      (tf),
        .t_lo    (t_lo_dly_reg[T_DLY-1]),
        .t_hi    (t_hi_dly_reg[T_DLY-1]),
        .hit     (hit),
        .t_entry (t_entry)
    );

endmodule

### rtl/rbst_checker.sv
`timescale 1ns / 1ps
// rbst_checker: port-level assertions for ray_box_slab_test, bound to the top level
module rbst_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input logic          hit,
    input rbst_pkg::fp_t t_entry
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(t_entry))
        else $error("stalled result changed");

    // a miss reports a zero entry distance
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> t_entry == 32'd0)
        else $error("miss with non-zero entry");

    // the sender is only held off by a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // nothing stalls while the receiver takes results
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_stall |-> !in_stall)
        else $error("input stalled while output free");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (.*);
